// ===== hdl/ite_pkg.sv =====
`default_nettype none

package ite_pkg;

    // Scan modes.
    localparam logic [1:0] MODE_SEARCH = 2'd0;
    localparam logic [1:0] MODE_MATCH  = 2'd1;
    localparam logic [1:0] MODE_UNQ    = 2'd2;
    localparam logic [1:0] MODE_QUOTED = 2'd3;

    // Edit commands for the downstream string buffer.
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_TRUNC  = 2'd1;
    localparam logic [1:0] CMD_DONE   = 2'd2;

    // Element delimiters and the leading prefix character.
    localparam logic [7:0] CH_LT = 8'h3C;
    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [7:0] CH_I  = 8'h49;

    // Length of the identifier prefix.
    localparam int PREFIX_LEN = 6;

    // Scanner state that fits in fixed widths.
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] prev;
        logic [7:0] quote;
        logic       in_elem;
        logic       after_elem;
        logic       ovf;
    } t_scan;

    // One result item.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  data;
        logic [10:0] length;
        logic        ovf;
    } t_result;

    // A result item with its valid flag.
    typedef struct packed {
        logic    vld;
        t_result res;
    } t_emit;

    // Whitespace: space, tab, newline, vertical tab, form feed, carriage return.
    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b inside {[8'h09:8'h0D]});
    endfunction

    // Marker bytes: quotes, backslash, brackets and a few symbols, plus all high bytes.
    function automatic logic is_marker(input logic [7:0] b);
        return b[7] || (b inside {8'h22, 8'h27, 8'h5C, 8'h40, 8'h3C, 8'h3E, 8'h21,
                                  8'h24, 8'h25, 8'h26, 8'h7B, 8'h7D, 8'h5B, 8'h5D});
    endfunction

    // Characters of the prefix "InChI=".
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0: c = 8'h49;
            3'd1: c = 8'h6E;
            3'd2: c = 8'h43;
            3'd3: c = 8'h68;
            3'd4: c = 8'h49;
            3'd5: c = 8'h3D;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ite_scan_pass.sv =====
`default_nettype none

module ite_scan_pass import ite_pkg::*; #(
    parameter int MAX_LEN = 1024,
    parameter int LW      = 11
) (
    input  wire logic          i_act,
    input  wire logic [7:0]    i_ch,
    input  wire t_scan         i_st,
    input  wire logic [LW-1:0] i_len,
    input  wire logic [LW-1:0] i_cut,
    output t_scan              o_st,
    output logic [LW-1:0]      o_len,
    output logic [LW-1:0]      o_cut,
    output logic               o_again,
    output t_emit              o_emit
);

    localparam logic [LW-1:0] MAXV     = LW'(MAX_LEN);
    localparam logic [LW-1:0] LAST_IDX = LW'(PREFIX_LEN - 1);
    localparam logic [LW-1:0] PLEN     = LW'(PREFIX_LEN);

    logic            app_req;
    logic            fin;
    logic            emit_v;
    logic [1:0]      emit_cmd;
    logic [7:0]      emit_data;
    logic [LW+10:0]  len_ext;

    always_comb begin
        o_st      = i_st;
        o_len     = i_len;
        o_cut     = i_cut;
        o_again   = 1'b0;
        app_req   = 1'b0;
        fin       = 1'b0;
        emit_v    = 1'b0;
        emit_cmd  = CMD_APPEND;
        emit_data = 8'h00;

        // Decide what this pass does with the byte.
        if (i_act) begin
            if (i_st.mode == MODE_SEARCH) begin
                if (i_ch == CH_I) begin
                    app_req    = 1'b1;
                    o_st.mode  = MODE_MATCH;
                    o_st.quote = i_st.prev;
                end
                o_st.prev = i_ch;
            end else if (i_ch == CH_LT) begin
                if (i_st.after_elem && i_st.mode == MODE_UNQ) begin
                    fin = 1'b1;
                end else begin
                    o_st.in_elem = 1'b1;
                end
            end else if (i_st.in_elem) begin
                if (i_st.after_elem) begin
                    // A non-space byte ends the element and is scanned again.
                    if (!is_space(i_ch)) begin
                        o_st.after_elem = 1'b0;
                        o_st.in_elem    = 1'b0;
                        o_again         = 1'b1;
                    end
                end else if (i_ch == CH_GT) begin
                    o_st.after_elem = 1'b1;
                end
            end else if (is_space(i_ch)) begin
                if (i_st.mode == MODE_UNQ) begin
                    fin = 1'b1;
                end
            end else if (is_marker(i_ch)) begin
                if (i_ch == i_st.quote && i_st.mode != MODE_MATCH) begin
                    fin = 1'b1;
                end else begin
                    // Text between two marker bytes is cut away.
                    if (i_cut != '0) begin
                        if (i_cut < i_len) begin
                            o_len = i_cut;
                        end
                        emit_v   = 1'b1;
                        emit_cmd = CMD_TRUNC;
                    end
                    o_cut = o_len;
                end
            end else if (i_st.mode == MODE_MATCH) begin
                if (i_len < PLEN && prefix_char(i_len[2:0]) == i_ch) begin
                    app_req = 1'b1;
                    if (i_len == LAST_IDX) begin
                        o_st.mode = (is_marker(i_st.quote) && i_st.quote != CH_GT) ?
                                    MODE_QUOTED : MODE_UNQ;
                    end
                end else begin
                    // Prefix mismatch: drop the partial string, rescan in search mode.
                    o_len     = '0;
                    emit_v    = 1'b1;
                    emit_cmd  = CMD_TRUNC;
                    o_st.mode = MODE_SEARCH;
                    o_again   = 1'b1;
                end
            end else begin
                app_req = 1'b1;
            end
        end

        // Append, or flag the overflow when the buffer is full.
        if (app_req) begin
            if (i_len >= MAXV) begin
                o_st.ovf = 1'b1;
            end else begin
                o_len     = i_len + 1'b1;
                emit_v    = 1'b1;
                emit_cmd  = CMD_APPEND;
                emit_data = i_ch;
            end
        end

        if (fin) begin
            emit_v   = 1'b1;
            emit_cmd = CMD_DONE;
        end

        // Build the result from the state as it stands before any completion reset.
        len_ext             = {11'b0, o_len};
        o_emit.vld          = emit_v;
        o_emit.res.cmd      = emit_cmd;
        o_emit.res.data     = emit_data;
        o_emit.res.length   = len_ext[10:0];
        o_emit.res.ovf      = o_st.ovf;

        // A completion returns all state to its reset value.
        if (fin) begin
            o_st  = '0;
            o_len = '0;
            o_cut = '0;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ite_out_fifo.sv =====
`default_nettype none

module ite_out_fifo import ite_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic [1:0] i_push_cnt,
    input  wire t_result i_rec_a,
    input  wire t_result i_rec_b,
    input  wire logic    i_pop,
    output logic [2:0]   o_count,
    output t_result      o_head
);

    localparam int DEPTH = 4;

    t_result    r_mem [DEPTH];
    logic [1:0] r_wr;
    logic [1:0] n_wr;
    logic [1:0] r_rd;
    logic [1:0] n_rd;
    logic [2:0] r_count;
    logic [2:0] n_count;
    logic [1:0] wr_b;

    assign wr_b = r_wr + 2'd1;

    // Up to two results enter per cycle, one leaves.
    always_comb begin
        n_wr    = r_wr + i_push_cnt;
        n_rd    = r_rd + {1'b0, i_pop};
        n_count = r_count + {1'b0, i_push_cnt} - {2'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_rec_a;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wr_b] <= i_rec_b;
        end
    end

    assign o_count = r_count;
    assign o_head  = r_mem[r_rd];

endmodule

`default_nettype wire

// ===== hdl/inchi_text_extractor.sv =====
// An input item passes through the input register and then the result queue; a second
// result of the same item waits in the queue behind the first.
// Throughput: one input item per cycle; results wait in a four-entry queue, and input
// stalls only while an item waits in the input register and that queue holds three or more.
// Reset (synchronous, active low) clears the scanner state, the input register
// and the result queue.
`default_nettype none

module inchi_text_extractor import ite_pkg::*; #(
    parameter int MAX_LEN = 1024
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_end_of_input,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [1:0]      o_command,
    output logic [7:0]      o_out_byte,
    output logic [10:0]     o_new_length,
    output logic            o_overflowed
);

    localparam int LW = $clog2(MAX_LEN + 1);

    // Input register.
    logic       r_in_valid;
    logic       n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eoi;

    // Scanner state.
    t_scan          r_st;
    t_scan          n_st;
    logic [LW-1:0]  r_len;
    logic [LW-1:0]  n_len;
    logic [LW-1:0]  r_cut;
    logic [LW-1:0]  n_cut;

    // Pass chain.
    t_scan          st1, st2, st3;
    logic [LW-1:0]  len1, len2, len3;
    logic [LW-1:0]  cut1, cut2, cut3;
    logic           ag1, ag2, ag3;
    t_emit          e0, e1, e2;

    logic           proc;
    logic           in_take;
    logic           pop;
    logic [1:0]     push_cnt;
    t_result        rec_a;
    t_result        rec_b;
    t_result        done_rec;
    logic [LW+10:0] len_ext;
    logic [2:0]     q_count;
    t_result        head;

    // An item is processed when the queue has room for two results.
    assign proc       = r_in_valid && (q_count <= 3'd2);
    assign o_in_stall = r_in_valid && !proc;
    assign in_take    = i_in_valid && !o_in_stall;
    assign n_in_valid = in_take || (r_in_valid && !proc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_eoi  <= i_end_of_input;
        end
    end

    // Up to three scan passes over the same byte.
    ite_scan_pass #(.MAX_LEN(MAX_LEN), .LW(LW)) u_pass0 (
        .i_act(1'b1), .i_ch(r_in_byte), .i_st(r_st), .i_len(r_len), .i_cut(r_cut),
        .o_st(st1), .o_len(len1), .o_cut(cut1), .o_again(ag1), .o_emit(e0)
    );

    ite_scan_pass #(.MAX_LEN(MAX_LEN), .LW(LW)) u_pass1 (
        .i_act(ag1), .i_ch(r_in_byte), .i_st(st1), .i_len(len1), .i_cut(cut1),
        .o_st(st2), .o_len(len2), .o_cut(cut2), .o_again(ag2), .o_emit(e1)
    );

    ite_scan_pass #(.MAX_LEN(MAX_LEN), .LW(LW)) u_pass2 (
        .i_act(ag2), .i_ch(r_in_byte), .i_st(st2), .i_len(len2), .i_cut(cut2),
        .o_st(st3), .o_len(len3), .o_cut(cut3), .o_again(ag3), .o_emit(e2)
    );

    // Completion at end of stream carries the current length and overflow flag.
    always_comb begin
        len_ext         = {11'b0, r_len};
        done_rec.cmd    = CMD_DONE;
        done_rec.data   = 8'h00;
        done_rec.length = len_ext[10:0];
        done_rec.ovf    = r_st.ovf;
    end

    // Pack the pass results into at most two queue entries.
    always_comb begin
        rec_a    = e2.res;
        rec_b    = e2.res;
        push_cnt = 2'd0;
        n_st     = r_st;
        n_len    = r_len;
        n_cut    = r_cut;
        if (proc) begin
            if (r_in_eoi) begin
                rec_a    = done_rec;
                push_cnt = 2'd1;
                n_st     = '0;
                n_len    = '0;
                n_cut    = '0;
            end else begin
                if (e0.vld) begin
                    rec_a = e0.res;
                    rec_b = e1.vld ? e1.res : e2.res;
                end else if (e1.vld) begin
                    rec_a = e1.res;
                    rec_b = e2.res;
                end
                push_cnt = {1'b0, e0.vld} + {1'b0, e1.vld} + {1'b0, e2.vld};
                n_st     = st3;
                n_len    = len3;
                n_cut    = cut3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= '0;
            r_len <= '0;
            r_cut <= '0;
        end else begin
            r_st  <= n_st;
            r_len <= n_len;
            r_cut <= n_cut;
        end
    end

    // Result queue and output channel.
    assign pop = o_out_valid && !i_out_stall;

    ite_out_fifo u_fifo (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push_cnt(push_cnt),
        .i_rec_a(rec_a),
        .i_rec_b(rec_b),
        .i_pop(pop),
        .o_count(q_count),
        .o_head(head)
    );

    assign o_out_valid  = (q_count != 3'd0);
    assign o_command    = head.cmd;
    assign o_out_byte   = head.data;
    assign o_new_length = head.length;
    assign o_overflowed = head.ovf;

endmodule

`default_nettype wire

// ===== hdl/ite_checker.sv =====
`default_nettype none

module ite_checker import ite_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic [7:0]  i_data_byte,
    input wire logic        i_end_of_input,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [1:0]  o_command,
    input wire logic [7:0]  o_out_byte,
    input wire logic [10:0] o_new_length,
    input wire logic        o_overflowed
);

    // Only the three defined commands ever leave the block.
    a_cmd_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_command == CMD_APPEND || o_command == CMD_TRUNC ||
                         o_command == CMD_DONE))
        else $error("illegal command code");

    // Truncate and complete items carry no byte.
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_command != CMD_APPEND) |-> (o_out_byte == 8'h00))
        else $error("non-append item carries a byte");

    // Reset empties both the input register and the result queue.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("block not idle after reset");

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_command) && $stable(o_out_byte) &&
             $stable(o_new_length) && $stable(o_overflowed)))
        else $error("stalled result changed");

endmodule

bind inchi_text_extractor ite_checker u_ite_checker (.*);

`default_nettype wire
